/* src/xyzlab_pkg.sv */
// ----------------------------------------------------------------------------
// xyzlab_pkg
// Shared types, constants and helpers for the XYZ to CIELAB converter.
// ----------------------------------------------------------------------------
package xyzlab_pkg;

   // ratio of a component to its white value, unsigned with 24 fraction bits
   localparam int RATIO_FRAC = 24;
   localparam int RATIO_W    = 27;
   typedef logic [RATIO_W-1:0] ratio_type;
   localparam ratio_type RATIO_MAX = ratio_type'(4) << RATIO_FRAC;

   // f(t) with 20 fraction bits
   localparam int F_W = 21;
   typedef logic [F_W-1:0] f_type;

   // threshold and linear segment constants
   localparam longint unsigned THR_K   = 24389;
   localparam longint unsigned THR_LIM = longint'(216) << RATIO_FRAC;
   localparam int LIN_R_W = 18;
   localparam int NUM_W   = 34;
   localparam logic [NUM_W-1:0] LIN_OFS = NUM_W'(432) << RATIO_FRAC;
   // divide by 50112 = 64 * 783: shift then reciprocal multiply
   localparam int M_W          = NUM_W - 6;
   localparam int RECIP_SHIFT  = 38;
   localparam int RECIP_W      = 29;
   localparam longint unsigned RECIP = ((longint'(1) << RECIP_SHIFT) + 782) / 783;
   localparam int PROD_W       = M_W + RECIP_W;

   // pipeline depths
   localparam int DIV_LAT = RATIO_W + 1;
   localparam int F_LAT   = F_W + 1;
   localparam int LAT     = DIV_LAT + F_LAT + 2;

   // output scaling
   localparam int L_MUL = 116;
   localparam int A_MUL = 32000;
   localparam int B_MUL = 12800;
   localparam int WIDE_W = 40;
   typedef logic signed [WIDE_W-1:0] wide_type;

   // configuration register indexes and reset values
   localparam logic [1:0] CSR_WHITE_X = 2'd0;
   localparam logic [1:0] CSR_WHITE_Y = 2'd1;
   localparam logic [1:0] CSR_WHITE_Z = 2'd2;
   localparam logic [15:0] WHITE_X_RST16 = 16'd31149;
   localparam logic [15:0] WHITE_Y_RST16 = 16'd32768;
   localparam logic [15:0] WHITE_Z_RST16 = 16'd35683;

   // divide by 2^s, rounding to nearest with halves away from zero
   function automatic wide_type round_shift(input wide_type v, input int s);
      logic     neg;
      wide_type mag;
      neg = v[WIDE_W-1];
      mag = neg ? -v : v;
      mag = (mag + (wide_type'(1) <<< (s - 1))) >>> s;
      return neg ? -mag : mag;
   endfunction

endpackage

/* src/xyzlab_if.sv */
// ----------------------------------------------------------------------------
// xyzlab interfaces
// Valid/ready channels for pixels in and CIELAB results out.
// ----------------------------------------------------------------------------
interface xyzlab_req_if #(parameter int IN_BITS = 16);
   logic               valid;
   logic               ready;
   logic [IN_BITS-1:0] x_tristim;
   logic [IN_BITS-1:0] y_tristim;
   logic [IN_BITS-1:0] z_tristim;

   modport source (output valid, x_tristim, y_tristim, z_tristim, input ready);
   modport sink   (input valid, x_tristim, y_tristim, z_tristim, output ready);
endinterface

interface xyzlab_rsp_if;
   logic               valid;
   logic               ready;
   logic [13:0]        lightness;
   logic signed [16:0] red_green;
   logic signed [15:0] yellow_blue;
   logic               ratio_saturated;

   modport source (output valid, lightness, red_green, yellow_blue, ratio_saturated,
                   input ready);
   modport sink   (input valid, lightness, red_green, yellow_blue, ratio_saturated,
                   output ready);
endinterface

/* src/xyzlab_ratio.sv */
// ----------------------------------------------------------------------------
// xyzlab_ratio
// Pipelined restoring divider: component / white with 24 fraction bits,
// one quotient bit per stage, clamped at 4.0.
// ----------------------------------------------------------------------------
module xyzlab_ratio
   import xyzlab_pkg::*;
#(
   parameter int IN_BITS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic [IN_BITS-1:0] comp,
   input  logic [IN_BITS-1:0] white,
   output ratio_type          ratio,
   output logic               sat
);

   localparam int DW = IN_BITS + RATIO_FRAC;
   localparam int CW = DW + 3;

   logic [DW-1:0] rem_ff [0:RATIO_W];
   ratio_type     quo_ff [0:RATIO_W];
   logic          hi_ff  [0:RATIO_W];
   logic          over;

   // load: quotient of 8.0 or more saturates outright
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {comp, {RATIO_FRAC{1'b0}}};
         quo_ff[0] <= '0;
         hi_ff[0]  <= {3'b000, comp} >= {white, 3'b000};
      end
   end

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < RATIO_W; k++) begin : g_bit
      localparam int B = RATIO_W - 1 - k;
      logic [CW-1:0] dsh;
      logic [CW-1:0] remx;
      logic [CW-1:0] diff;
      logic          ge;

      always_comb begin
         dsh  = CW'(white) << B;
         remx = {3'b000, rem_ff[k]};
         ge   = remx >= dsh;
         diff = remx - dsh;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[DW-1:0] : rem_ff[k];
            quo_ff[k+1] <= quo_ff[k] | (ge ? (ratio_type'(1) << B) : '0);
            hi_ff[k+1]  <= hi_ff[k];
         end
      end
   end

   // clamp above 4.0
   always_comb begin
      over  = hi_ff[RATIO_W] ||
              (quo_ff[RATIO_W][RATIO_W-1] && (|quo_ff[RATIO_W][RATIO_W-2:0]));
      sat   = over;
      ratio = over ? RATIO_MAX : quo_ff[RATIO_W];
   end

endmodule

/* src/xyzlab_f.sv */
// ----------------------------------------------------------------------------
// xyzlab_f
// Pipelined f(t): digit-by-digit cube root, one result bit per stage, with
// the linear segment computed alongside and selected at the end.
// ----------------------------------------------------------------------------
module xyzlab_f
   import xyzlab_pkg::*;
(
   input  logic      clock,
   input  logic      en,
   input  ratio_type ratio,
   output f_type     f_out
);

   localparam int N_W = 3 * F_W;

   ratio_type          r_ff    [0:F_W];
   logic               thr_ff  [0:F_W];
   f_type              res_ff  [0:F_W];
   logic [2*F_W-1:0]   sq_ff   [0:F_W];
   logic [N_W-1:0]     cube_ff [0:F_W];
   f_type              lin_ff  [2:F_W];
   logic [NUM_W-1:0]   num_ff;
   logic [PROD_W-1:0]  prod_ff;

   // entry: threshold test and linear numerator
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= ratio;
         thr_ff[0]  <= (64'(ratio) * THR_K) > THR_LIM;
         res_ff[0]  <= '0;
         sq_ff[0]   <= '0;
         cube_ff[0] <= '0;
         num_ff     <= NUM_W'(ratio[LIN_R_W-1:0]) * NUM_W'(THR_K) + LIN_OFS;
      end
   end

   // linear segment: reciprocal multiply, then delay line
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= PROD_W'(num_ff[NUM_W-1:6]) * PROD_W'(RECIP);
         lin_ff[2] <= F_W'(prod_ff >> RECIP_SHIFT);
      end
   end

   for (genvar k = 3; k <= F_W; k++) begin : g_lin
      always_ff @(posedge clock) begin
         if (en) lin_ff[k] <= lin_ff[k-1];
      end
   end

   // cube root stages, msb first, tracking res, res^2 and res^3
   for (genvar j = 0; j < F_W; j++) begin : g_root
      localparam int B = F_W - 1 - j;
      logic [63:0] cand_cube;
      logic [63:0] cand_sq;
      logic [63:0] n;
      logic        take;

      always_comb begin
         n = 64'({r_ff[j], 36'b0});
         cand_cube = 64'(cube_ff[j])
                   + (((64'(sq_ff[j]) << 1) + 64'(sq_ff[j])) << B)
                   + (((64'(res_ff[j]) << 1) + 64'(res_ff[j])) << (2 * B))
                   + (64'(1) << (3 * B));
         cand_sq = 64'(sq_ff[j]) + (64'(res_ff[j]) << (B + 1)) + (64'(1) << (2 * B));
         take = cand_cube <= n;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j+1]   <= r_ff[j];
            thr_ff[j+1] <= thr_ff[j];
            res_ff[j+1] <= take ? (res_ff[j] | (f_type'(1) << B)) : res_ff[j];
            sq_ff[j+1]  <= take ? cand_sq[2*F_W-1:0] : sq_ff[j];
            cube_ff[j+1] <= take ? cand_cube[N_W-1:0] : cube_ff[j];
         end
      end
   end

   assign f_out = thr_ff[F_W] ? res_ff[F_W] : lin_ff[F_W];

endmodule

/* src/xyz_to_cielab_conversion.sv */
// ----------------------------------------------------------------------------
// xyz_to_cielab_conversion
// CIE XYZ pixel in, CIELAB L*, a*, b* out, relative to a programmable white.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless a result is stalled; each pixel passes
// through the ratio divider (one quotient bit per stage, 28 stages), then
// the cube root (one root bit per stage, 22 stages) and two stages of
// scaling and rounding. A stall on the result side holds the whole
// pipeline. The user writes white point registers through the csr port only
// while no pixel is in flight (not enforced by the block); indexes 0, 1, 2
// select X, Y, Z, other indexes are ignored. Outputs are in units of 1/64;
// ratio_saturated flags any component ratio clamped at 4.0 (a zero white component always clamps).
// ----------------------------------------------------------------------------
module xyz_to_cielab_conversion
   import xyzlab_pkg::*;
#(
   parameter int IN_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   xyzlab_req_if.sink         req_ch,
   xyzlab_rsp_if.source       rsp_ch,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [IN_BITS-1:0] csr_wdata
);

   localparam logic [23:0] WX24 = {WHITE_X_RST16, 8'h00};
   localparam logic [23:0] WY24 = {WHITE_Y_RST16, 8'h00};
   localparam logic [23:0] WZ24 = {WHITE_Z_RST16, 8'h00};
   localparam logic [IN_BITS-1:0] WX_RST = IN_BITS'(WX24 >> (24 - IN_BITS));
   localparam logic [IN_BITS-1:0] WY_RST = IN_BITS'(WY24 >> (24 - IN_BITS));
   localparam logic [IN_BITS-1:0] WZ_RST = IN_BITS'(WZ24 >> (24 - IN_BITS));

   logic [IN_BITS-1:0] white_x_ff, white_y_ff, white_z_ff;
   logic [LAT-1:0]     vld_ff;
   logic               adv;

   ratio_type rx, ry, rz;
   logic      sx, sy, sz;
   f_type     fx, fy, fz;

   logic [F_LAT-1:0]   sat_d_ff;
   logic               sat_m_ff;
   wide_type           lm_ff, am_ff, bm_ff;
   logic signed [21:0] da, db;
   wide_type           lr, ar, br;

   logic [13:0]        l_ff;
   logic signed [16:0] a_ff;
   logic signed [15:0] b_ff;
   logic               s_ff;

   // white point registers
   always_ff @(posedge clock) begin
      if (reset) begin
         white_x_ff <= WX_RST;
         white_y_ff <= WY_RST;
         white_z_ff <= WZ_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WHITE_X: white_x_ff <= csr_wdata;
            CSR_WHITE_Y: white_y_ff <= csr_wdata;
            CSR_WHITE_Z: white_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a result waits
   assign adv          = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
      end
   end

   // ratio dividers
   xyzlab_ratio #(.IN_BITS(IN_BITS)) u_ratio_x (
      .clock(clock), .en(adv), .comp(req_ch.x_tristim), .white(white_x_ff),
      .ratio(rx), .sat(sx));
   xyzlab_ratio #(.IN_BITS(IN_BITS)) u_ratio_y (
      .clock(clock), .en(adv), .comp(req_ch.y_tristim), .white(white_y_ff),
      .ratio(ry), .sat(sy));
   xyzlab_ratio #(.IN_BITS(IN_BITS)) u_ratio_z (
      .clock(clock), .en(adv), .comp(req_ch.z_tristim), .white(white_z_ff),
      .ratio(rz), .sat(sz));

   // f(t) units
   xyzlab_f u_f_x (.clock(clock), .en(adv), .ratio(rx), .f_out(fx));
   xyzlab_f u_f_y (.clock(clock), .en(adv), .ratio(ry), .f_out(fy));
   xyzlab_f u_f_z (.clock(clock), .en(adv), .ratio(rz), .f_out(fz));

   // saturation flag delay alongside f
   always_ff @(posedge clock) begin
      if (adv) sat_d_ff <= {sat_d_ff[F_LAT-2:0], sx | sy | sz};
   end

   // scaling multiplies
   always_comb begin
      da = $signed({1'b0, fx}) - $signed({1'b0, fy});
      db = $signed({1'b0, fy}) - $signed({1'b0, fz});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lm_ff    <= wide_type'($signed({1'b0, fy})) * wide_type'(L_MUL)
                   - (wide_type'(16) <<< F_W - 1);
         am_ff    <= wide_type'(da) * wide_type'(A_MUL);
         bm_ff    <= wide_type'(db) * wide_type'(B_MUL);
         sat_m_ff <= sat_d_ff[F_LAT-1];
      end
   end

   // rounding and output register
   always_comb begin
      lr = round_shift(lm_ff, F_W - 7);
      ar = round_shift(am_ff, F_W - 1);
      br = round_shift(bm_ff, F_W - 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_ff <= lr[WIDE_W-1] ? '0 : lr[13:0];
         a_ff <= ar[16:0];
         b_ff <= br[15:0];
         s_ff <= sat_m_ff;
      end
   end

   assign rsp_ch.valid           = vld_ff[LAT-1];
   assign rsp_ch.lightness       = l_ff;
   assign rsp_ch.red_green       = a_ff;
   assign rsp_ch.yellow_blue     = b_ff;
   assign rsp_ch.ratio_saturated = s_ff;

   // a held result blocks new transfers
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while result stalled");

   // lightness within cube root of 4 bound
   a_l_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.lightness <= 14'd10762)
      else $error("lightness out of range");

   // a* within bound set by f range
   a_a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.red_green <= 17'sd50800) &&
                       (rsp_ch.red_green >= -17'sd50800))
      else $error("red_green out of range");

endmodule

/* bench/xyzlab_tb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xyzlab_tb_checker
// Watches the pixel and result channels, predicts CIELAB values for every
// accepted pixel from its own copy of the white point, and compares them.
// ----------------------------------------------------------------------------
module xyzlab_tb_checker
   import xyzlab_pkg::*;
#(
   parameter int IN_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   xyzlab_req_if              req_ch,
   xyzlab_rsp_if              rsp_ch,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [IN_BITS-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending_count,
   output int                 result_count,
   output int                 sat_count
);

   typedef struct packed {
      logic [13:0]        lightness;
      logic signed [16:0] red_green;
      logic signed [15:0] yellow_blue;
      logic               ratio_saturated;
   } lab_type;

   lab_type lab_queue[$];
   logic [IN_BITS-1:0] wp_x, wp_y, wp_z;

   assign pending_count = lab_queue.size();

   // component over white, 24 fraction bits, clamped at 4.0
   function automatic longint unsigned ratio_of(input longint unsigned c,
                                                input longint unsigned w,
                                                inout logic sat);
      longint unsigned q;
      q = (w == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (c << 24) / w;
      if (q > (64'd4 << 24)) begin
         sat = 1'b1;
         q   = 64'd4 << 24;
      end
      return q;
   endfunction

   // f(t) with 20 fraction bits
   function automatic longint lab_curve(input longint unsigned r);
      longint unsigned n, root, c;
      if (r * 24389 > (64'd216 << 24)) begin
         n    = r << 36;
         root = 0;
         for (int bit_i = 20; bit_i >= 0; bit_i--) begin
            c = root | (64'd1 << bit_i);
            if (c * c * c <= n) root = c;
         end
         return longint'(root);
      end
      return longint'((r * 24389 + (64'd432 << 24)) / 50112);
   endfunction

   function automatic longint round_div(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
   endfunction

   function automatic lab_type predict_lab(input logic [IN_BITS-1:0] x,
                                           input logic [IN_BITS-1:0] y,
                                           input logic [IN_BITS-1:0] z);
      logic    sat;
      longint  fx, fy, fz, l_v, a_v, b_v;
      lab_type res;
      sat = 1'b0;
      fx  = lab_curve(ratio_of(x, wp_x, sat));
      fy  = lab_curve(ratio_of(y, wp_y, sat));
      fz  = lab_curve(ratio_of(z, wp_z, sat));
      l_v = round_div(116 * fy - (longint'(16) << 20), 14);
      a_v = round_div(32000 * (fx - fy), 20);
      b_v = round_div(12800 * (fy - fz), 20);
      if (l_v < 0) l_v = 0;
      res.lightness       = l_v[13:0];
      res.red_green       = a_v[16:0];
      res.yellow_blue     = b_v[15:0];
      res.ratio_saturated = sat;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial fail_count = 0;

   // track white point, predict on pixel transfer, compare on result transfer
   always @(posedge clock) begin
      lab_type want;
      if (reset) begin
         wp_x         <= IN_BITS'((32'(WHITE_X_RST16) << 8) >> (24 - IN_BITS));
         wp_y         <= IN_BITS'((32'(WHITE_Y_RST16) << 8) >> (24 - IN_BITS));
         wp_z         <= IN_BITS'((32'(WHITE_Z_RST16) << 8) >> (24 - IN_BITS));
         result_count <= 0;
         sat_count    <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WHITE_X: wp_x <= csr_wdata;
               CSR_WHITE_Y: wp_y <= csr_wdata;
               CSR_WHITE_Z: wp_z <= csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            lab_queue.push_back(predict_lab(req_ch.x_tristim, req_ch.y_tristim,
                                            req_ch.z_tristim));
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count <= result_count + 1;
            if (lab_queue.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               want = lab_queue.pop_front();
               if (want.ratio_saturated) sat_count <= sat_count + 1;
               if (rsp_ch.lightness !== want.lightness)
                  report_mismatch("lightness", rsp_ch.lightness, want.lightness);
               if (rsp_ch.red_green !== want.red_green)
                  report_mismatch("red_green", rsp_ch.red_green, want.red_green);
               if (rsp_ch.yellow_blue !== want.yellow_blue)
                  report_mismatch("yellow_blue", rsp_ch.yellow_blue,
                                  want.yellow_blue);
               if (rsp_ch.ratio_saturated !== want.ratio_saturated)
                  report_mismatch("ratio_saturated", rsp_ch.ratio_saturated,
                                  want.ratio_saturated);
            end
         end
      end
   end

endmodule

/* bench/xyz_to_cielab_conversion_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xyz_to_cielab_conversion_tb
// Drives pixels and white point settings into the converter with random
// gaps and result stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module xyz_to_cielab_conversion_tb;
   import xyzlab_pkg::*;

   localparam int IN_BITS    = 16;
   localparam int DRAIN_WAIT = LAT + 20;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [IN_BITS-1:0] csr_wdata;
   int fail_count, pending_count, result_count, sat_count;
   int cycle_count;
   int pixel_count;
   int phase_count;

   xyzlab_req_if #(.IN_BITS(IN_BITS)) req_ch ();
   xyzlab_rsp_if rsp_ch ();

   xyz_to_cielab_conversion #(.IN_BITS(IN_BITS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   xyzlab_tb_checker #(.IN_BITS(IN_BITS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .sat_count     (sat_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side stalls: a random wait before each transfer, quiet stretches
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // global timeout
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [IN_BITS-1:0] x, input logic [IN_BITS-1:0] y,
                             input logic [IN_BITS-1:0] z, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.x_tristim <= x;
      req_ch.y_tristim <= y;
      req_ch.z_tristim <= z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pixel_count++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_white(input logic [1:0] idx, input logic [IN_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [IN_BITS-1:0] pick_tristim();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return IN_BITS'($urandom_range(0, 400));
         3: return IN_BITS'($urandom_range(30000, 36000));
         default: return IN_BITS'($urandom);
      endcase
   endfunction

   // random pixels under the current white point
   task automatic random_pixels(input int count);
      bit gaps;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) gaps = ($urandom_range(0, 2) != 0);
         send_pixel(pick_tristim(), pick_tristim(), pick_tristim(), gaps);
      end
   endtask

   initial begin
      logic [IN_BITS-1:0] wx, wy, wz;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_WHITE_X;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.x_tristim = '0;
      req_ch.y_tristim = '0;
      req_ch.z_tristim = '0;
      pixel_count  = 0;
      phase_count  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: black, white, full scale, threshold edge, mixed extremes
      send_pixel(16'd0, 16'd0, 16'd0, 1'b0);
      send_pixel(16'd31149, 16'd32768, 16'd35683, 1'b0);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_pixel(16'd290, 16'd290, 16'd290, 1'b0);
      send_pixel(16'd291, 16'd291, 16'd291, 1'b0);
      send_pixel(16'd0, 16'hFFFF, 16'd0, 1'b1);
      send_pixel(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
      send_pixel(16'hAAAA, 16'h5555, 16'h0001, 1'b1);
      drain_results();

      // small white: ratio exactly 4.0 versus clamped
      write_white(CSR_WHITE_X, 16'd16384);
      write_white(CSR_WHITE_Y, 16'd1);
      write_white(CSR_WHITE_Z, 16'd8192);
      send_pixel(16'hFFFF, 16'd4, 16'd32768, 1'b0);
      send_pixel(16'hFFFF, 16'd5, 16'd32769, 1'b0);
      send_pixel(16'd0, 16'd0, 16'd0, 1'b0);
      drain_results();

      // zero white components clamp even with zero input; bad index ignored
      write_white(CSR_WHITE_X, 16'd0);
      write_white(CSR_WHITE_Y, 16'hFFFF);
      write_white(CSR_WHITE_Z, 16'd0);
      write_white(2'd3, 16'd7);
      send_pixel(16'd0, 16'd0, 16'd0, 1'b0);
      send_pixel(16'd0, 16'hFFFF, 16'd123, 1'b1);
      send_pixel(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
      drain_results();

      // random phases with varied white points, extremes among them
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin wx = 16'd31149; wy = 16'd32768; wz = 16'd35683; end
            1: begin wx = 16'hFFFF;  wy = 16'hFFFF;  wz = 16'hFFFF;  end
            2: begin wx = 16'd1;     wy = 16'd1;     wz = 16'd1;     end
            default: begin
               wx = IN_BITS'($urandom_range(1, 65535));
               wy = IN_BITS'($urandom_range(1, 65535));
               wz = IN_BITS'($urandom_range(1, 65535));
            end
         endcase
         write_white(CSR_WHITE_X, wx);
         write_white(CSR_WHITE_Y, wy);
         write_white(CSR_WHITE_Z, wz);
         random_pixels(120);
         drain_results();
         phase_count++;
      end

      $display("pixels sent %0d, results checked %0d, saturated %0d",
               pixel_count, result_count, sat_count);
      $display("white point phases %0d plus directed corner cases", phase_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
src/xyzlab_pkg.sv
src/xyzlab_if.sv
src/xyzlab_ratio.sv
src/xyzlab_f.sv
src/xyz_to_cielab_conversion.sv
bench/xyzlab_tb_checker.sv
bench/xyz_to_cielab_conversion_tb.sv
